// ----- src/chp_pkg.sv -----
// ----------------------------------------------------------------------------
// Characteristic polynomial package
// Shared widths, defaults, types and helpers for the Berkowitz engine.
// ----------------------------------------------------------------------------
package chp_pkg;

    localparam int DEF_MAX_DIM    = 16;
    localparam int DEF_ENTRY_BITS = 16;
    localparam int COEF_W         = 64;
    localparam int IDX_W          = 5;
    localparam int SIZE_W         = 5;
    localparam int SIZE_RESET     = 16;

    typedef logic [COEF_W-1:0] word_t;

    localparam word_t SIGN_WORD = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct packed {
        logic start;
        logic clear;
    } mac_cmd_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } mac_res_t;

    function automatic word_t neg_word(input word_t x);
        return '0 - x;
    endfunction

endpackage

// ----- src/chp_ifs.sv -----
// ----------------------------------------------------------------------------
// Characteristic polynomial channels
// Valid/ready channels for matrix entries and polynomial coefficients.
// ----------------------------------------------------------------------------
interface chp_entry_if #(parameter int ENTRY_BITS = chp_pkg::DEF_ENTRY_BITS);
    logic                         valid;
    logic                         ready;
    logic signed [ENTRY_BITS-1:0] entry;

    modport source (output valid, output entry, input ready);
    modport sink   (input valid, input entry, output ready);
endinterface

interface chp_coef_if;
    import chp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] coefficient;
    logic [IDX_W-1:0]         power_index;
    logic                     last;
    logic                     overflow;

    modport source (output valid, output coefficient, output power_index, output last,
                    output overflow, input ready);
    modport sink   (input valid, input coefficient, input power_index, input last,
                    input overflow, output ready);
endinterface

// ----- src/characteristic_polynomial.sv -----
// Load: n*n entry transfers, then the multiply-accumulates run one at a time on the one
// shared 32x32-partial multiplier; the engine waits for each product before starting the next.
// Results: n+1 coefficient transfers, one per cycle when the sink is ready.
// Throughput: one matrix per load + compute + output; input stalls during compute.
// Reset: asynchronous active low; size returns to 16, loading restarts at entry 0.
// ----------------------------------------------------------------------------
// Characteristic polynomial engine
// Berkowitz division-free characteristic polynomial of a loaded integer matrix.
// ----------------------------------------------------------------------------
module characteristic_polynomial #(
    parameter int MAX_DIM    = chp_pkg::DEF_MAX_DIM,
    parameter int ENTRY_BITS = chp_pkg::DEF_ENTRY_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [chp_pkg::SIZE_W-1:0] cfg_wdata,
    chp_entry_if.sink                  entries,
    chp_coef_if.source                 coefs
);
    import chp_pkg::*;

    localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW_N  = 2 * (2 ** DW);

    localparam logic [3:0] S_LOAD    = 4'd0;
    localparam logic [3:0] S_DIAG_F  = 4'd1;
    localparam logic [3:0] S_DIAG    = 4'd2;
    localparam logic [3:0] S_PW_F    = 4'd3;
    localparam logic [3:0] S_PW      = 4'd4;
    localparam logic [3:0] S_MAC_F   = 4'd5;
    localparam logic [3:0] S_MAC_S   = 4'd6;
    localparam logic [3:0] S_MAC_W   = 4'd7;
    localparam logic [3:0] S_JOB_END = 4'd8;
    localparam logic [3:0] S_FOLD    = 4'd9;
    localparam logic [3:0] S_NEXT_ID = 4'd10;
    localparam logic [3:0] S_EMIT    = 4'd11;

    localparam logic [1:0] JOB_ALPHA = 2'd0;
    localparam logic [1:0] JOB_SPOW  = 2'd1;
    localparam logic [1:0] JOB_COEF  = 2'd2;

    logic [SIZE_W-1:0] size_reg;
    logic [3:0]        state_reg, state_next;
    logic [1:0]        job_reg, job_next;
    logic [AW-1:0]     load_pos_reg, load_pos_next;
    logic [CW-1:0]     id_reg, id_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     row_reg, row_next;
    logic [CW-1:0]     t_reg, t_next;
    logic [CW-1:0]     ek_reg, ek_next;
    logic              bank_reg, bank_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg;
    word_t             out_coef_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic              out_last_reg;
    logic              out_ovf_reg;

    word_t             col_reg  [MAX_DIM+1];
    word_t             coef_reg [MAX_DIM+1];
    word_t             pw_reg   [PW_N];

    logic [CW-1:0]     n;
    logic [2*CW-1:0]   nn;
    logic [2*CW:0]     pos_inc;
    logic [CW-1:0]     s;
    logic [CW-1:0]     m;
    logic [CW-1:0]     t_last;
    logic [CW-1:0]     rd_r;
    logic [CW-1:0]     rd_c;
    logic [2*CW-1:0]   lin;
    logic [AW-1:0]     raddr;
    logic [ENTRY_BITS-1:0] q;
    word_t             q_ext;
    logic [CW-1:0]     coef_idx;
    word_t             coef_rd;
    word_t             pw_rd;
    word_t             op_a;
    word_t             op_b;
    logic              in_xfer;
    logic              emit_load;
    mac_cmd_t          mac_cmd;
    mac_res_t          mac_res;
    word_t             mac_acc;

    always_comb
    begin
        if (size_reg == '0)
        begin
            n = CW'(1);
        end
        else if (int'(size_reg) > MAX_DIM)
        begin
            n = CW'(MAX_DIM);
        end
        else
        begin
            n = CW'(size_reg);
        end
    end

    assign nn      = n * n;
    assign pos_inc = (2*CW+1)'(load_pos_reg) + (2*CW+1)'(1);
    assign s       = n - id_reg;
    assign m       = s - CW'(1);
    assign in_xfer = entries.valid && entries.ready;

    assign entries.ready = (state_reg == S_LOAD);

    always_comb
    begin
        if (job_reg == JOB_COEF)
        begin
            t_last = (row_reg < m) ? row_reg : m;
        end
        else
        begin
            t_last = m - CW'(1);
        end
    end

    always_comb
    begin
        rd_r = '0;
        rd_c = '0;
        case (state_reg)
            S_DIAG_F:
            begin
                rd_r = id_reg;
                rd_c = id_reg;
            end
            S_PW_F:
            begin
                rd_r = id_reg + CW'(1) + row_reg;
                rd_c = id_reg;
            end
            S_MAC_F:
            begin
                if (job_reg == JOB_ALPHA)
                begin
                    rd_r = id_reg;
                    rd_c = id_reg + CW'(1) + t_reg;
                end
                else
                begin
                    rd_r = id_reg + CW'(1) + row_reg;
                    rd_c = id_reg + CW'(1) + t_reg;
                end
            end
            default:
            begin
                rd_r = '0;
                rd_c = '0;
            end
        endcase
    end

    assign lin   = rd_r * n + (2*CW)'(rd_c);
    assign raddr = lin[AW-1:0];

    chp_store #(
        .DEPTH      (DEPTH),
        .AW         (AW),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_store (
        .clk   (clk),
        .we    (in_xfer),
        .waddr (load_pos_reg),
        .wdata (entries.entry),
        .raddr (raddr),
        .rdata (q)
    );

    assign q_ext    = {{(COEF_W-ENTRY_BITS){q[ENTRY_BITS-1]}}, q};
    assign coef_idx = (state_reg == S_EMIT) ? ek_reg : t_reg;
    assign coef_rd  = coef_reg[coef_idx];
    assign pw_rd    = pw_reg[{bank_reg, t_reg[DW-1:0]}];
    assign op_a     = (job_reg == JOB_COEF) ? col_reg[row_reg - t_reg] : q_ext;
    assign op_b     = (job_reg == JOB_COEF) ? coef_rd : pw_rd;

    assign mac_cmd.start = (state_reg == S_MAC_S);
    assign mac_cmd.clear = (t_reg == '0);

    chp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .a     (op_a),
        .b     (op_b),
        .res   (mac_res),
        .acc   (mac_acc)
    );

    assign emit_load = (state_reg == S_EMIT) && (!out_valid_reg || coefs.ready);

    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        load_pos_next = load_pos_reg;
        id_next       = id_reg;
        k_next        = k_reg;
        row_next      = row_reg;
        t_next        = t_reg;
        ek_next       = ek_reg;
        bank_next     = bank_reg;
        ovf_next      = ovf_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_xfer)
                begin
                    if (pos_inc == (2*CW+1)'(nn))
                    begin
                        load_pos_next = '0;
                        id_next       = n - CW'(1);
                        ovf_next      = 1'b0;
                        bank_next     = 1'b0;
                        state_next    = S_DIAG_F;
                    end
                    else
                    begin
                        load_pos_next = pos_inc[AW-1:0];
                    end
                end
            end
            S_DIAG_F:
            begin
                state_next = S_DIAG;
            end
            S_DIAG:
            begin
                ovf_next = ovf_reg | (q_ext == SIGN_WORD);
                row_next = '0;
                state_next = (m == '0) ? S_FOLD : S_PW_F;
            end
            S_PW_F:
            begin
                state_next = S_PW;
            end
            S_PW:
            begin
                if (row_reg == m - CW'(1))
                begin
                    k_next     = '0;
                    job_next   = JOB_ALPHA;
                    t_next     = '0;
                    state_next = S_MAC_F;
                end
                else
                begin
                    row_next   = row_reg + CW'(1);
                    state_next = S_PW_F;
                end
            end
            S_MAC_F:
            begin
                state_next = S_MAC_S;
            end
            S_MAC_S:
            begin
                state_next = S_MAC_W;
            end
            S_MAC_W:
            begin
                if (mac_res.done)
                begin
                    ovf_next = ovf_reg | mac_res.ovf;
                    if (t_reg == t_last)
                    begin
                        state_next = S_JOB_END;
                    end
                    else
                    begin
                        t_next     = t_reg + CW'(1);
                        state_next = S_MAC_F;
                    end
                end
            end
            S_JOB_END:
            begin
                t_next = '0;
                case (job_reg)
                    JOB_ALPHA:
                    begin
                        ovf_next = ovf_reg | (mac_acc == SIGN_WORD);
                        if (k_reg + CW'(1) < m)
                        begin
                            job_next   = JOB_SPOW;
                            row_next   = '0;
                            state_next = S_MAC_F;
                        end
                        else
                        begin
                            state_next = S_FOLD;
                        end
                    end
                    JOB_SPOW:
                    begin
                        state_next = S_MAC_F;
                        if (row_reg == m - CW'(1))
                        begin
                            bank_next = ~bank_reg;
                            k_next    = k_reg + CW'(1);
                            job_next  = JOB_ALPHA;
                        end
                        else
                        begin
                            row_next = row_reg + CW'(1);
                        end
                    end
                    default:
                    begin
                        if (row_reg == '0)
                        begin
                            state_next = S_NEXT_ID;
                        end
                        else
                        begin
                            row_next   = row_reg - CW'(1);
                            state_next = S_MAC_F;
                        end
                    end
                endcase
            end
            S_FOLD:
            begin
                if (id_reg == n - CW'(1))
                begin
                    state_next = S_NEXT_ID;
                end
                else
                begin
                    job_next   = JOB_COEF;
                    row_next   = s;
                    t_next     = '0;
                    state_next = S_MAC_F;
                end
            end
            S_NEXT_ID:
            begin
                if (id_reg == '0)
                begin
                    ek_next    = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    id_next    = id_reg - CW'(1);
                    state_next = S_DIAG_F;
                end
            end
            S_EMIT:
            begin
                if (emit_load)
                begin
                    if (ek_reg == n)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        ek_next = ek_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
        if (cfg_we)
        begin
            load_pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_W'(SIZE_RESET);
            state_reg     <= S_LOAD;
            job_reg       <= JOB_ALPHA;
            load_pos_reg  <= '0;
            id_reg        <= '0;
            k_reg         <= '0;
            row_reg       <= '0;
            t_reg         <= '0;
            ek_reg        <= '0;
            bank_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            state_reg    <= state_next;
            job_reg      <= job_next;
            load_pos_reg <= load_pos_next;
            id_reg       <= id_next;
            k_reg        <= k_next;
            row_reg      <= row_next;
            t_reg        <= t_next;
            ek_reg       <= ek_next;
            bank_reg     <= bank_next;
            ovf_reg      <= ovf_next;
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (coefs.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIAG)
        begin
            col_reg[0] <= word_t'(1);
            col_reg[1] <= neg_word(q_ext);
        end
        if (state_reg == S_PW)
        begin
            pw_reg[{bank_reg, row_reg[DW-1:0]}] <= q_ext;
        end
        if (state_reg == S_JOB_END)
        begin
            case (job_reg)
                JOB_ALPHA: col_reg[k_reg + CW'(2)]               <= neg_word(mac_acc);
                JOB_SPOW:  pw_reg[{~bank_reg, row_reg[DW-1:0]}] <= mac_acc;
                default:   coef_reg[row_reg]                    <= mac_acc;
            endcase
        end
        if (state_reg == S_FOLD && id_reg == n - CW'(1))
        begin
            coef_reg[0] <= word_t'(1);
            coef_reg[1] <= col_reg[1];
        end
        if (emit_load)
        begin
            out_coef_reg <= coef_rd;
            out_idx_reg  <= IDX_W'(ek_reg);
            out_last_reg <= (ek_reg == n);
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign coefs.valid       = out_valid_reg;
    assign coefs.coefficient = out_coef_reg;
    assign coefs.power_index = out_idx_reg;
    assign coefs.last        = out_last_reg;
    assign coefs.overflow    = out_ovf_reg;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mac_res.done |-> state_reg == S_MAC_W)
        else $error("multiply-accumulate finished outside its wait state");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (coefs.valid && coefs.last) |-> coefs.power_index == IDX_W'(n))
        else $error("constant term transfer carries the wrong power index");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC_S) |=> !entries.ready)
        else $error("entry transfer possible while a product is in flight");
`endif

endmodule

// ----- src/chp_store.sv -----
// ----------------------------------------------------------------------------
// Matrix store
// Single write port, single registered read port entry memory.
// ----------------------------------------------------------------------------
module chp_store #(
    parameter int DEPTH      = 256,
    parameter int AW         = 8,
    parameter int ENTRY_BITS = 16
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [ENTRY_BITS-1:0] wdata,
    input  logic [AW-1:0]         raddr,
    output logic [ENTRY_BITS-1:0] rdata
);

    logic [ENTRY_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/chp_mac.sv -----
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Signed 64x64 product from four 32x32 partials, overflow checked, added
// into a wrapping 64-bit accumulator.
// ----------------------------------------------------------------------------
module chp_mac (
    input  logic              clk,
    input  logic              rst_n,
    input  chp_pkg::mac_cmd_t cmd,
    input  chp_pkg::word_t    a,
    input  chp_pkg::word_t    b,
    output chp_pkg::mac_res_t res,
    output chp_pkg::word_t    acc
);
    import chp_pkg::*;

    logic         busy_reg;
    logic [2:0]   step_reg;
    logic         done_reg;
    logic         ovf_reg;
    word_t        ma_reg;
    word_t        mb_reg;
    logic         neg_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_sh_reg;
    logic [127:0] prod_reg;
    word_t        acc_reg;

    logic [31:0]  x_half;
    logic [31:0]  y_half;
    logic [63:0]  pp_now;
    logic [1:0]   sh_now;
    logic [127:0] pp_shifted;
    word_t        limit;
    word_t        lo;
    word_t        prod_s;
    word_t        sum;
    word_t        carry_v;
    logic         mul_ovf;
    logic         final_step;

    assign x_half = step_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign y_half = step_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
    assign pp_now = x_half * y_half;
    assign sh_now = {1'b0, step_reg[1]} + {1'b0, step_reg[0]};

    always_comb
    begin
        case (pp_sh_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_shifted = {pp_reg, 64'd0};
            default: pp_shifted = '0;
        endcase
    end

    assign lo         = prod_reg[63:0];
    assign limit      = neg_reg ? SIGN_WORD : SIGN_WORD - 64'd1;
    assign mul_ovf    = (prod_reg[127:64] != 64'd0) || (lo > limit);
    assign prod_s     = neg_reg ? neg_word(lo) : lo;
    assign sum        = acc_reg + prod_s;
    assign carry_v    = ~(acc_reg ^ prod_s) & (acc_reg ^ sum);
    assign final_step = busy_reg && (step_reg == 3'd5);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= final_step;
            ovf_reg  <= final_step && (mul_ovf || carry_v[63]);
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (final_step)
                begin
                    busy_reg <= 1'b0;
                end
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            ma_reg   <= a[63] ? neg_word(a) : a;
            mb_reg   <= b[63] ? neg_word(b) : b;
            neg_reg  <= a[63] ^ b[63];
            prod_reg <= '0;
            if (cmd.clear)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (step_reg <= 3'd3)
            begin
                pp_reg    <= pp_now;
                pp_sh_reg <= sh_now;
            end
            if (step_reg >= 3'd1 && step_reg <= 3'd4)
            begin
                prod_reg <= prod_reg + pp_shifted;
            end
            if (final_step)
            begin
                acc_reg <= sum;
            end
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign acc      = acc_reg;

endmodule
